FILE: hdl/swm_pkg.sv
package swm_pkg;

   localparam int SAMPLE_W = 32;

   // command broadcast from the control logic to every cell
   typedef struct packed {
      logic                       load;    // replace the oldest entry
      logic                       prime;   // first sample: fill the whole row
      logic signed [SAMPLE_W-1:0] sample;
   } swm_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       gt;      // stored value above the new sample
   } swm_link_type;

endpackage

FILE: hdl/swm_cell.sv
module swm_cell #(
   parameter int TAG_W = 6,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  swm_pkg::swm_cmd_type cmd,
   input  logic [TAG_W-1:0]     slot,
   input  logic                 del_below,
   input  swm_pkg::swm_link_type lower_link,
   input  logic [TAG_W-1:0]     lower_tag,
   input  swm_pkg::swm_link_type upper_link,
   input  logic [TAG_W-1:0]     upper_tag,
   output swm_pkg::swm_link_type self_link,
   output logic [TAG_W-1:0]     self_tag,
   output logic                 self_del
);
   import swm_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [TAG_W-1:0]           tag_ff, tag_in;
   logic                       gt_self;
   logic                       rem_gt, rem_lo_gt;
   logic signed [SAMPLE_W-1:0] rem_value, rem_lo_value;
   logic [TAG_W-1:0]           rem_tag, rem_lo_tag;

   assign gt_self   = value_ff > cmd.sample;
   assign self_del  = (tag_ff == slot);
   assign self_link = '{value: value_ff, gt: gt_self};
   assign self_tag  = tag_ff;

   // entry at this place and one below once the oldest entry is gone
   always_comb begin
      if (del_below || self_del) begin
         rem_gt    = upper_link.gt;
         rem_value = upper_link.value;
         rem_tag   = upper_tag;
      end else begin
         rem_gt    = gt_self;
         rem_value = value_ff;
         rem_tag   = tag_ff;
      end
      if (del_below) begin
         rem_lo_gt    = gt_self;
         rem_lo_value = value_ff;
         rem_lo_tag   = tag_ff;
      end else begin
         rem_lo_gt    = lower_link.gt;
         rem_lo_value = lower_link.value;
         rem_lo_tag   = lower_tag;
      end
   end

   always_comb begin
      value_in = value_ff;
      tag_in   = tag_ff;
      if (cmd.prime) begin
         value_in = cmd.sample;
         tag_in   = TAG_W'(INDEX);
      end else if (cmd.load) begin
         if (!rem_gt) begin
            value_in = rem_value;
            tag_in   = rem_tag;
         end else if (!rem_lo_gt) begin
            value_in = cmd.sample;
            tag_in   = slot;
         end else begin
            value_in = rem_lo_value;
            tag_in   = rem_lo_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tag_ff   <= tag_in;
   end

endmodule

FILE: hdl/sliding_window_median_unit.sv
// Running median filter over the latest WINDOW signed Q16.16 samples. Every
// sample accepted on the req_ channel gives exactly one result on the rsp_
// channel: the window element of ascending rank WINDOW/2 (counted from 0, so
// the upper median for an even window) after the sample has entered. The
// first sample after reset fills the whole window with copies of itself. The
// window lives in a sorted row of WINDOW cells, each holding one sample and
// the ring slot it was written to; every cell compares its value with the
// new sample, the cell holding the oldest slot drops out and the row shifts
// around it so the new sample lands in sorted order. One sample is taken per
// clock cycle unless rsp_tready holds the result; the result is registered,
// appears in the cycle after its transfer, and the next sample is taken in
// the same cycle it is read. The cycle time is set by the compare across the
// cell row and the OR of the drop-out flags below each cell.
module sliding_window_median_unit #(
   parameter int WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] median
);
   import swm_pkg::*;

   localparam int TAG_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MID   = WINDOW / 2;

   logic             primed_ff, primed_in;
   logic [TAG_W-1:0] oldest_ff, oldest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   swm_cmd_type      cmd;

   swm_link_type     link    [WINDOW];
   logic [TAG_W-1:0] tag_arr [WINDOW];
   logic [WINDOW-1:0] del_vec;
   logic [WINDOW-1:0] below_vec;

   // input side: free whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cmd.load   = accept && primed_ff;
   assign cmd.prime  = accept && !primed_ff;
   assign cmd.sample = req_tdata;

   // control registers
   always_comb begin
      primed_in    = primed_ff || accept;
      oldest_in    = oldest_ff;
      if (cmd.load) begin
         oldest_in = (oldest_ff == TAG_W'(WINDOW - 1)) ? '0 : oldest_ff + 1'b1;
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sorted row of cells, lowest value at index 0
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      swm_link_type     lo_link, up_link;
      logic [TAG_W-1:0] lo_tag, up_tag;

      // the bottom cell sees nothing below it that exceeds the sample
      if (i == 0) begin : g_bottom
         assign lo_link   = '{value: '0, gt: 1'b0};
         assign lo_tag    = '0;
         assign below_vec[i] = 1'b0;
      end else begin : g_lower
         assign lo_link   = link[i-1];
         assign lo_tag    = tag_arr[i-1];
         assign below_vec[i] = |del_vec[i-1:0];
      end

      // past the top sits an empty place that sorts above everything
      if (i == WINDOW - 1) begin : g_top
         assign up_link = '{value: '0, gt: 1'b1};
         assign up_tag  = '0;
      end else begin : g_upper
         assign up_link = link[i+1];
         assign up_tag  = tag_arr[i+1];
      end

      swm_cell #(
         .TAG_W (TAG_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot       (oldest_ff),
         .del_below  (below_vec[i]),
         .lower_link (lo_link),
         .lower_tag  (lo_tag),
         .upper_link (up_link),
         .upper_tag  (up_tag),
         .self_link  (link[i]),
         .self_tag   (tag_arr[i]),
         .self_del   (del_vec[i])
      );
   end

   // the middle cell always holds the current median
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = link[MID].value;

   // exactly one cell holds the slot that is about to be overwritten
   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $onehot(del_vec))
      else $error("oldest slot not held by exactly one cell");

   // every transfer in leaves a result pending on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("result missing after input transfer");

   // no result before the window has been filled
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> !rsp_tvalid)
      else $error("result before first sample");

   // ring pointer stays inside the window
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= TAG_W'(WINDOW - 1))
      else $error("oldest slot out of range");

endmodule
